[rtl/mi4_pkg.sv]
// ============================================================================
// mi4_pkg: shared types and constants for the 4x4 matrix inverse block
// Holds the front-to-back job descriptor and the register map.
// ============================================================================
`default_nettype none
package mi4_pkg;
    localparam int CFG_TRANSPOSE_OUT = 0;
    localparam int CFG_NUM_REGS = 1;
    localparam int CFG_ADDR_W = 3;

    typedef struct packed {
        logic transpose;
    } job_t;
endpackage
`default_nettype wire

[rtl/mi4_front.sv]
// ============================================================================
// mi4_front: element loader
// Collects 16 elements into the matrix store; on the 16th, hands a job
// (matrix snapshot plus transpose mode) to the back end through a 2-deep queue.
// ============================================================================
`default_nettype none
module mi4_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  elem_value,
    input  wire logic                transpose_out,
    output logic                     job_valid,
    input  wire logic                job_take,
    output mi4_pkg::job_t            job,
    output logic [511:0]             job_mat
);
    logic [31:0]   mat_reg [16];
    logic [3:0]    load_count_reg;
    logic [511:0]  q_mat_reg [2];
    mi4_pkg::job_t q_job_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic [511:0]  snap;
    logic          acc, enq;

    assign full = (load_count_reg == 4'd15) && (cnt_reg == 2'd2);
    assign acc  = push && !full;
    assign enq  = acc && (load_count_reg == 4'd15);

    always_comb
    begin
        for (int i = 0; i < 15; i++)
            snap[i*32 +: 32] = mat_reg[i];
        snap[480 +: 32] = elem_value;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            mat_reg[load_count_reg] <= elem_value;
        if (enq)
        begin
            q_mat_reg[wr_ptr_reg] <= snap;
            q_job_reg[wr_ptr_reg].transpose <= transpose_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (acc)
                load_count_reg <= load_count_reg + 4'd1;
            if (enq)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (job_take && job_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, enq} - {1'b0, job_take && job_valid};
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job     = q_job_reg[rd_ptr_reg];
    assign job_mat = q_mat_reg[rd_ptr_reg];
endmodule
`default_nettype wire

[rtl/mi4_back.sv]
// ============================================================================
// mi4_back: cofactor, determinant and division sequencer
// A 32x32 multiplier forms the 2x2 minors; a shared 33x32 signed multiplier
// builds each cofactor term and the determinant 32 bits at a time; a
// bit-serial restoring divider produces each quotient.
// ============================================================================
`default_nettype none
module mi4_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output logic                     job_take,
    input  wire mi4_pkg::job_t       job,
    input  wire logic [511:0]        job_mat,
    output logic                     res_valid,
    input  wire logic                res_take,
    output logic signed [31:0]       res_value,
    output logic [3:0]               res_index,
    output logic                     res_singular,
    output logic                     res_saturated,
    output logic                     res_last
);
    localparam int NW = 96 + 2 * FRAC_BITS;   // numerator: |C|<2^96, shifted 2F
    localparam int DW = 128;                  // |det| < 2^128
    localparam logic [2:0] S_IDLE = 3'd0, S_COF = 3'd1, S_DET = 3'd2,
                           S_CHK = 3'd3, S_LOAD = 3'd4, S_DIV = 3'd5,
                           S_OUT = 3'd6;

    logic [2:0]   state_reg;
    logic [31:0]  m_reg [16];
    logic signed [127:0] cof_reg [16];
    logic         tr_reg;
    logic [3:0]   cof_idx_reg;     // cofactor entry j*4+i
    logic [3:0]   step_reg;        // micro step inside a cofactor
    logic signed [63:0]  p_reg;    // 2x2 minor products
    logic signed [63:0]  mn_reg;
    logic signed [127:0] acc_reg;
    logic signed [DW:0]  det_reg;
    logic [3:0]   k_reg;
    logic [NW-1:0] num_reg;
    logic [DW:0]  rem_reg;
    logic [7:0]   bit_reg;
    logic         neg_reg;
    logic         out_v_reg;

    // cofactor (i,j) is stored at j*4+i
    logic [1:0] ci, cj;
    logic [1:0] rr0, rr1, rr2, cc0, cc1, cc2, ca, cb, ck;
    logic [1:0] kk;
    assign ci = cof_idx_reg[1:0];
    assign cj = cof_idx_reg[3:2];

    function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] n);
        return (n >= x) ? n + 2'd1 : n;
    endfunction

    function automatic logic signed [31:0] el(input logic [1:0] r, input logic [1:0] c,
                                              input logic [31:0] m [16]);
        return $signed(m[{r, c}]);
    endfunction

    // step: kk = term index, phase = step_reg[1:0]
    // (0:a*b 1:-b*a 2:low half *elem 3:high half *elem)
    assign kk  = step_reg[3:2];
    assign rr0 = skip(ci, 2'd0);
    assign rr1 = skip(ci, 2'd1);
    assign rr2 = skip(ci, 2'd2);
    assign cc0 = skip(cj, 2'd0);
    assign cc1 = skip(cj, 2'd1);
    assign cc2 = skip(cj, 2'd2);
    always_comb
    begin
        unique case (kk)
            2'd0:    begin ca = cc1; cb = cc2; ck = cc0; end
            2'd1:    begin ca = cc0; cb = cc2; ck = cc1; end
            default: begin ca = cc0; cb = cc1; ck = cc2; end
        endcase
    end

    logic signed [63:0] mul32;
    assign mul32 = (step_reg[1:0] == 2'd0)
                 ? el(rr1, ca, m_reg) * el(rr2, cb, m_reg)
                 : el(rr1, cb, m_reg) * el(rr2, ca, m_reg);

    // determinant operand: limb step_reg[1:0] of cofactor (0,j), j = step_reg[3:2]
    logic signed [127:0] dcof;
    logic [31:0]         dlimb;
    assign dcof  = cof_reg[{step_reg[3:2], 2'b00}];
    assign dlimb = dcof[{step_reg[1:0], 5'd0} +: 32];

    // shared 33x32 multiplier: lower limbs unsigned, top limb signed
    logic signed [32:0] wa;
    logic signed [31:0] wb;
    logic signed [64:0] wp;
    always_comb
    begin
        if (state_reg == S_DET)
        begin
            wa = {(step_reg[1:0] == 2'd3) ? dlimb[31] : 1'b0, dlimb};
            wb = $signed(m_reg[{2'b00, step_reg[3:2]}]);
        end
        else
        begin
            wa = step_reg[0] ? {mn_reg[63], mn_reg[63:32]} : {1'b0, mn_reg[31:0]};
            wb = el(rr0, ck, m_reg);
        end
    end
    assign wp = wa * wb;

    logic signed [127:0] wterm;
    logic signed [DW:0]  dterm;
    assign wterm = step_reg[0] ? (128'(wp) <<< 32) : 128'(wp);
    assign dterm = (DW + 1)'(wp) <<< {step_reg[1:0], 5'd0};

    logic [3:0] src;
    assign src = tr_reg ? {k_reg[1:0], k_reg[3:2]} : k_reg;

    logic signed [127:0] cs;
    logic [NW-1:0] cmag;
    assign cs   = cof_reg[src];
    assign cmag = NW'(cs[127] ? -cs : cs) << (2 * FRAC_BITS);

    logic [DW:0] rsh, rsub;
    logic [DW-1:0] adet;
    assign adet = DW'(det_reg[DW] ? -det_reg : det_reg);
    assign rsh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign rsub = rsh - {1'b0, adet};

    logic [NW-1:0] q;
    assign q = num_reg;   // after NW steps num_reg holds the quotient

    assign job_take = (state_reg == S_IDLE) && job_valid;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (job_valid)
                begin
                    for (int n = 0; n < 16; n++)
                        m_reg[n] <= job_mat[n*32 +: 32];
                    tr_reg <= job.transpose;
                    acc_reg <= '0;
                    det_reg <= '0;
                end
            S_COF:
                unique case (step_reg[1:0])
                    2'd0: p_reg <= mul32;
                    2'd1: mn_reg <= p_reg - mul32;
                    2'd2: acc_reg <= (kk == 2'd1) ? acc_reg - wterm : acc_reg + wterm;
                    default:
                        if (kk == 2'd2)
                            cof_reg[{cj, ci}] <= (ci[0] ^ cj[0]) ? -(acc_reg + wterm)
                                                                  : acc_reg + wterm;
                        else if (kk == 2'd1)
                            acc_reg <= acc_reg - wterm;
                        else
                            acc_reg <= acc_reg + wterm;
                endcase
            S_DET:
                det_reg <= det_reg + dterm;
            S_LOAD:
            begin
                num_reg <= cmag;
                rem_reg <= '0;
                neg_reg <= cs[127] ^ det_reg[DW];
            end
            S_DIV:
                if (rsub[DW])
                begin
                    rem_reg <= rsh;
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= rsub;
                    num_reg <= {num_reg[NW-2:0], 1'b1};
                end
            default: ;
        endcase
        if (state_reg == S_COF && step_reg[1:0] == 2'd3 && kk == 2'd2)
            acc_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cof_idx_reg <= '0;
            step_reg <= '0;
            k_reg <= '0;
            bit_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (res_take && out_v_reg)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        state_reg <= S_COF;
                        cof_idx_reg <= '0;
                        step_reg <= '0;
                    end
                S_COF:
                    if (step_reg[1:0] == 2'd3)
                    begin
                        if (kk == 2'd2)
                        begin
                            step_reg <= '0;
                            cof_idx_reg <= cof_idx_reg + 4'd1;
                            if (cof_idx_reg == 4'd15)
                                state_reg <= S_DET;
                        end
                        else
                            step_reg <= {kk + 2'd1, 2'd0};
                    end
                    else
                        step_reg <= step_reg + 4'd1;
                S_DET:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= S_CHK;
                end
                S_CHK:
                    if (!out_v_reg)
                    begin
                        if (det_reg == '0)
                        begin
                            out_v_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                S_LOAD:
                begin
                    bit_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    bit_reg <= bit_reg + 8'd1;
                    if (bit_reg == 8'(NW - 1))
                        state_reg <= S_OUT;
                end
                default:
                    if (!out_v_reg)
                    begin
                        out_v_reg <= 1'b1;
                        k_reg <= k_reg + 4'd1;
                        state_reg <= (k_reg == 4'd15) ? S_IDLE : S_LOAD;
                    end
            endcase
        end
    end

    // result register
    logic hi;
    assign hi = |q[NW-1:32];
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHK && !out_v_reg && det_reg == '0)
        begin
            res_value <= '0;
            res_index <= '0;
            res_singular <= 1'b1;
            res_saturated <= 1'b0;
            res_last <= 1'b1;
        end
        else if (state_reg == S_OUT && !out_v_reg)
        begin
            res_index <= k_reg;
            res_singular <= 1'b0;
            res_last <= (k_reg == 4'd15);
            if (!neg_reg)
            begin
                res_saturated <= hi || q[31];
                res_value <= (hi || q[31]) ? 32'h7fffffff : q[31:0];
            end
            else
            begin
                res_saturated <= hi || (q[31:0] > 32'h80000000);
                res_value <= (hi || (q[31:0] > 32'h80000000)) ? 32'h80000000
                                                               : 32'd0 - q[31:0];
            end
        end
    end
    assign res_valid = out_v_reg;
endmodule
`default_nettype wire

[rtl/matrix_inverse_4x4_top.sv]
// ============================================================================
// matrix_inverse_4x4_top: 4x4 fixed-point matrix inverse (adjugate method)
// Loads 16 row-major Q elements, then emits 16 inverse elements or one
// singular transaction.
// ============================================================================
//  channel | handshake        | payload
//  input   | push / full      | elem_value
//  result  | pop / empty      | out_value, out_index, singular, saturated, last
//  config  | APB psel/penable | transpose_out at 0x0
//
//  Loading takes one cycle per element while full is low; the 16th element
//  queues a job (two jobs deep) so the next matrix can load while one is worked on.
//  Per matrix the back end forms the 16 cofactors (12 steps each, wide
//  products split into 32-bit halves), then the determinant (four
//  32-bit limbs per column), then each result in the bit-serial divider.
//  Reset clears counters, queue and mode; stores hold no reset.
//  A stalled result simply pauses the back end.
`default_nettype none
module matrix_inverse_4x4_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  elem_value,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [31:0]       out_value,
    output logic [3:0]               out_index,
    output logic                     singular,
    output logic                     saturated,
    output logic                     last,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [mi4_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic          transpose_reg;
    logic          job_valid, job_take, res_valid;
    mi4_pkg::job_t job;
    logic [511:0]  job_mat;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            transpose_reg <= 1'b0;
        else if (psel && penable && pwrite
                 && paddr == 3'(mi4_pkg::CFG_TRANSPOSE_OUT * 4))
            transpose_reg <= pwdata[0];
    end
    assign prdata = (paddr == 3'(mi4_pkg::CFG_TRANSPOSE_OUT * 4)) ? {31'd0, transpose_reg}
                                                                  : 32'd0;

    mi4_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .elem_value(elem_value), .transpose_out(transpose_reg),
        .job_valid(job_valid), .job_take(job_take), .job(job), .job_mat(job_mat)
    );

    mi4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .job_mat(job_mat), .res_valid(res_valid), .res_take(pop),
        .res_value(out_value), .res_index(out_index), .res_singular(singular),
        .res_saturated(saturated), .res_last(last)
    );
    assign empty = !res_valid;

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && singular) |-> (last && out_index == 4'd0 && out_value == 32'sd0))
        else $error("singular transaction malformed");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");
endmodule
`default_nettype wire
